FILE: rtl/kbl_pkg.sv
package kbl_pkg;

    // operation codes carried in the request tuser
    localparam logic [2:0] OP_LINE_BYTE = 3'd0;
    localparam logic [2:0] OP_TICK      = 3'd1;
    localparam logic [2:0] OP_START_RX  = 3'd2;
    localparam logic [2:0] OP_TRANSMIT  = 3'd3;
    localparam logic [2:0] OP_CONNECT   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT   = 3'd1;
    localparam logic [2:0] ERR_BAD_COMPL = 3'd2;
    localparam logic [2:0] ERR_BAD_CNT   = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
    localparam logic [2:0] ERR_BAD_SYNC  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_FIRST_TO = 2'd0;
    localparam logic [1:0] REG_BYTE_TO  = 2'd1;
    localparam logic [1:0] REG_MAX_LEN  = 2'd2;

    localparam logic [15:0] FIRST_TO_RST = 16'd2000;
    localparam logic [15:0] BYTE_TO_RST  = 16'd1000;
    localparam logic [6:0]  MAX_LEN_RST  = 7'd64;

    localparam logic [7:0] COMPL_MASK = 8'hFF;
    localparam logic [1:0] SYNC_LEN   = 2'd3;

    // link engine modes
    typedef enum logic [5:0] {
        M_IDLE     = 6'b000001,
        M_CONN     = 6'b000010,
        M_CONN_BAD = 6'b000100,
        M_RECV     = 6'b001000,
        M_TXWAIT   = 6'b010000,
        M_TXREADY  = 6'b100000
    } t_mode;

    // one result item, first field highest
    typedef struct packed {
        logic       busy_res;
        logic [7:0] counter_now;
        logic       link_up;
        logic [2:0] error_code;
        logic       block_done;
        logic [5:0] rx_index;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } t_result;

    localparam int RES_BITS  = $bits(t_result);
    localparam int RES_BYTES = (RES_BITS + 7) / 8;
    localparam int OUT_BITS  = RES_BYTES * 8;

    // expected sync byte at a position of the connect sequence
    function automatic logic [7:0] sync_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = 8'h55;
            2'd1:    b = 8'h01;
            2'd2:    b = 8'h8A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/kline_block_link_unit.sv
// channel   | dir | signals                          | contents
// ----------+-----+----------------------------------+----------------------------------
// request   | in  | i_s_tvalid/o_s_tready            | tdata: data[7:0]; tlast: last;
//           |     | i_s_tdata/i_s_tlast/i_s_tuser    | tuser: operation[2:0]
// result    | out | o_m_tvalid/i_m_tready/o_m_tdata  | one result per request, see port
// config    | in  | psel/penable/pwrite/paddr/pwdata | APB, regs at 0x0, 0x4, 0x8
//
// each request is folded into the link state in the cycle it is accepted, and its
// result appears in the output register on the next cycle: one request per cycle.
// the output register decouples the sides; a new request is taken while the held
// result is being taken in the same cycle.
// a stall on the result side holds the output register and drops o_s_tready.
// reset (synchronous, active low) puts the engine idle, clears the block counter
// and loads the timeout and length registers with their defaults.
module kline_block_link_unit #(
    parameter int MAX_BLOCK = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // data[7:0]
    input  logic                           i_s_tlast,
    input  logic [2:0]                     i_s_tuser,   // operation[2:0]
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tx_valid[0] tx_byte[8:1] rx_valid[9] rx_byte[17:10] rx_index[23:18]
    // block_done[24] error_code[27:25] link_up[28] counter_now[36:29]
    // busy_res[37] zero[39:38]
    output logic [kbl_pkg::OUT_BITS-1:0]   o_m_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import kbl_pkg::*;

    localparam logic [7:0] MaxBlk = 8'(MAX_BLOCK);

    // state
    t_mode       r_mode,        n_mode;
    logic [6:0]  r_byte_count,  n_byte_count;
    logic [6:0]  r_block_len,   n_block_len;
    logic [7:0]  r_block_cnt,   n_block_cnt;
    logic [15:0] r_wait_timer,  n_wait_timer;
    logic        r_connected,   n_connected;
    logic [7:0]  r_sent_byte,   n_sent_byte;
    logic        r_sent_last,   n_sent_last;

    logic [15:0] r_first_to;
    logic [15:0] r_byte_to;
    logic [6:0]  r_max_len;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic        accept;
    logic        cfg_wr;
    logic [2:0]  op;
    logic [7:0]  din;
    logic        waiting;
    logic [7:0]  lim;
    logic [8:0]  size;
    logic [7:0]  cnt;
    logic [7:0]  pos_next;
    logic        ok;
    logic        sync_bad;
    logic [2:0]  err;
    logic        done;

    assign op     = i_s_tuser;
    assign din    = i_s_tdata;
    assign accept = i_s_tvalid && o_s_tready;

    // handshake and output register
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_BITS'(r_out);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_FIRST_TO: prdata = {16'd0, r_first_to};
            REG_BYTE_TO:  prdata = {16'd0, r_byte_to};
            REG_MAX_LEN:  prdata = {25'd0, r_max_len};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_to <= FIRST_TO_RST;
            r_byte_to  <= BYTE_TO_RST;
            r_max_len  <= MAX_LEN_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FIRST_TO: r_first_to <= pwdata[15:0];
                REG_BYTE_TO:  r_byte_to  <= pwdata[15:0];
                REG_MAX_LEN:  r_max_len  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // helpers for the receive path
    assign waiting  = (r_mode == M_CONN) || (r_mode == M_CONN_BAD) ||
                      (r_mode == M_RECV) || (r_mode == M_TXWAIT);
    assign lim      = ({1'b0, r_max_len} < MaxBlk) ? {1'b0, r_max_len} : MaxBlk;
    assign size     = {1'b0, din} + 9'd1;
    assign cnt      = {1'b0, r_byte_count} + 8'd1;
    assign pos_next = cnt;
    assign sync_bad = (r_byte_count < 7'(SYNC_LEN)) &&
                      (din != sync_byte(r_byte_count[1:0]));

    // link engine next state and result
    always_comb begin
        n_mode       = r_mode;
        n_byte_count = r_byte_count;
        n_block_len  = r_block_len;
        n_block_cnt  = r_block_cnt;
        n_wait_timer = r_wait_timer;
        n_connected  = r_connected;
        n_sent_byte  = r_sent_byte;
        n_sent_last  = r_sent_last;
        n_out        = '0;
        err          = ERR_NONE;
        done         = 1'b0;
        ok           = 1'b1;

        unique case (op)
            OP_CONNECT: begin
                n_block_cnt  = 8'd0;
                n_byte_count = 7'd0;
                n_block_len  = 7'(SYNC_LEN);
                n_wait_timer = r_first_to;
                n_mode       = M_CONN;
            end
            OP_START_RX: begin
                n_byte_count = 7'd0;
                n_block_len  = 7'd0;
                n_wait_timer = r_first_to;
                n_mode       = M_RECV;
            end
            OP_TRANSMIT: begin
                if (r_mode == M_IDLE || r_mode == M_TXREADY) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = din;
                    n_sent_byte    = din;
                    n_sent_last    = i_s_tlast;
                    if (i_s_tlast) begin
                        done        = 1'b1;
                        n_block_cnt = r_block_cnt + 8'd1;
                        n_mode      = M_IDLE;
                    end else begin
                        n_wait_timer = r_byte_to;
                        n_mode       = M_TXWAIT;
                    end
                end
            end
            OP_TICK: begin
                if (waiting) begin
                    if (r_wait_timer <= 16'd1) begin
                        n_wait_timer = 16'd0;
                        err          = ERR_TIMEOUT;
                        n_connected  = 1'b0;
                        n_mode       = M_IDLE;
                    end else begin
                        n_wait_timer = r_wait_timer - 16'd1;
                    end
                end
            end
            OP_LINE_BYTE: begin
                if (r_mode == M_CONN || r_mode == M_CONN_BAD) begin
                    // sync byte of the connect sequence
                    n_out.rx_valid = 1'b1;
                    n_out.rx_byte  = din;
                    n_out.rx_index = r_byte_count[5:0];
                    if (sync_bad) begin
                        n_mode = M_CONN_BAD;
                    end
                    n_byte_count = pos_next[6:0];
                    n_wait_timer = r_byte_to;
                    if (pos_next >= 8'(SYNC_LEN)) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = din ^ COMPL_MASK;
                        n_block_cnt    = r_block_cnt + 8'd1;
                        if (r_mode == M_CONN && !sync_bad) begin
                            n_connected = 1'b1;
                            done        = 1'b1;
                            n_mode      = M_IDLE;
                        end else begin
                            err         = ERR_BAD_SYNC;
                            n_connected = 1'b0;
                            n_mode      = M_IDLE;
                        end
                    end
                end else if (r_mode == M_RECV) begin
                    // block byte: length, counter, then payload
                    if (cnt == 8'd1) begin
                        if (size > {1'b0, lim}) begin
                            err    = ERR_TOO_LONG;
                            n_mode = M_IDLE;
                            ok     = 1'b0;
                        end else begin
                            n_block_len = size[6:0];
                        end
                    end else if (cnt == 8'd2 && din != r_block_cnt) begin
                        err         = ERR_BAD_CNT;
                        n_connected = 1'b0;
                        n_mode      = M_IDLE;
                        ok          = 1'b0;
                    end
                    if (ok) begin
                        n_out.rx_valid = 1'b1;
                        n_out.rx_byte  = din;
                        n_out.rx_index = r_byte_count[5:0];
                        n_byte_count   = cnt[6:0];
                        n_wait_timer   = r_byte_to;
                        if (cnt < {1'b0, n_block_len}) begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = din ^ COMPL_MASK;
                        end else begin
                            done        = 1'b1;
                            n_block_cnt = r_block_cnt + 8'd1;
                            n_mode      = M_IDLE;
                        end
                    end
                end else if (r_mode == M_TXWAIT) begin
                    // partner's complement of the byte just sent
                    if (din == (r_sent_byte ^ COMPL_MASK)) begin
                        n_mode = M_TXREADY;
                    end else begin
                        err         = ERR_BAD_COMPL;
                        n_connected = 1'b0;
                        n_mode      = M_IDLE;
                    end
                end
            end
            default: ;
        endcase

        n_out.block_done  = done;
        n_out.error_code  = err;
        n_out.link_up     = n_connected;
        n_out.counter_now = n_block_cnt;
        n_out.busy_res    = (n_mode != M_IDLE);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_byte_count <= 7'd0;
            r_block_len  <= 7'd0;
            r_block_cnt  <= 8'd0;
            r_wait_timer <= 16'd0;
            r_connected  <= 1'b0;
            r_sent_byte  <= 8'd0;
            r_sent_last  <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_byte_count <= n_byte_count;
            r_block_len  <= n_block_len;
            r_block_cnt  <= n_block_cnt;
            r_wait_timer <= n_wait_timer;
            r_connected  <= n_connected;
            r_sent_byte  <= n_sent_byte;
            r_sent_last  <= n_sent_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // checks
    a_connect_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_CONNECT) |=> (r_mode == M_CONN && r_block_cnt == 8'd0))
        else $error("connect request did not clear the block counter");

    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.block_done && r_out.error_code != ERR_NONE))
        else $error("block done reported together with an error");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != ERR_NONE) |-> !r_out.busy_res)
        else $error("engine still busy after an error");

    a_err_drops_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_code == ERR_TIMEOUT ||
                         r_out.error_code == ERR_BAD_COMPL ||
                         r_out.error_code == ERR_BAD_CNT ||
                         r_out.error_code == ERR_BAD_SYNC)) |-> !r_out.link_up)
        else $error("link kept after a link error");

    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tx_valid) |-> (r_out.tx_byte == 8'd0))
        else $error("tx byte set without tx valid");

endmodule
